/* design/pwag_pkg.sv */
// Shared types and constants for the perspective warp address generator.
package pwag_pkg;

    localparam int NUM_REGS = 8;
    localparam int COEF_W   = 32;
    localparam int IDX_W    = 4;
    localparam int SEL_W    = 3;
    localparam int PROD_W   = 42;
    localparam int SUM_W    = 44;
    localparam int Q_BITS   = 14;
    localparam int CMP_W    = SUM_W + Q_BITS;
    localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(65536);

    localparam logic [SEL_W-1:0] REG_X_COL = 3'd0;
    localparam logic [SEL_W-1:0] REG_X_ROW = 3'd1;
    localparam logic [SEL_W-1:0] REG_X_OFF = 3'd2;
    localparam logic [SEL_W-1:0] REG_Y_COL = 3'd3;
    localparam logic [SEL_W-1:0] REG_Y_ROW = 3'd4;
    localparam logic [SEL_W-1:0] REG_Y_OFF = 3'd5;
    localparam logic [SEL_W-1:0] REG_W_COL = 3'd6;
    localparam logic [SEL_W-1:0] REG_W_ROW = 3'd7;

    localparam logic [COEF_W-1:0] COEF_ONE  = 32'd65536;
    localparam logic [COEF_W-1:0] COEF_ZERO = 32'd0;

    typedef logic [NUM_REGS-1:0][COEF_W-1:0] t_coefs;

    // identity matrix, highest index first
    localparam t_coefs COEF_RESET = {COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE,
                                     COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE};

    typedef struct packed {
        logic [8:0] out_row;
        logic [8:0] out_col;
    } t_in;

    typedef struct packed {
        logic [9:0] src_x;
        logic [9:0] src_y;
        logic       inside_res;
        logic [8:0] dest_row;
        logic [8:0] dest_col;
    } t_out;

    typedef struct packed {
        logic [8:0] dest_row;
        logic [8:0] dest_col;
        logic       neg_x;
        logic       neg_y;
        logic       ov_x;
        logic       ov_y;
        logic       w_zero;
    } t_side;

endpackage

/* design/pwag_mac.sv */
// Multiply, sum and magnitude stages of the homography map.
module pwag_mac #(
    parameter int OUT_SIZE = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_valid,
    input  pwag_pkg::t_in                   i_in,
    input  pwag_pkg::t_coefs                i_coefs,
    output logic                            o_valid,
    output pwag_pkg::t_side                 o_side,
    output logic [pwag_pkg::SUM_W-1:0]      o_mx,
    output logic [pwag_pkg::SUM_W-1:0]      o_my,
    output logic [pwag_pkg::SUM_W-1:0]      o_md
);
    import pwag_pkg::*;

    logic signed [PROD_W-1:0] r_p [6];
    logic signed [COEF_W-1:0] r_offx, r_offy;
    logic [8:0]               r_dr1, r_dc1, r_dr2, r_dc2;
    logic                     r_v1, r_v2, r_v3;
    logic signed [SUM_W-1:0]  r_sx, r_sy, r_sw;
    logic signed [SUM_W-1:0]  n_sx, n_sy, n_sw;
    logic signed [9:0]        s_col, s_row;
    logic [SUM_W-1:0]         a_x, a_y, a_w;
    logic [CMP_W-1:0]         w_sh;

    assign s_col = $signed({1'b0, i_in.out_col});
    assign s_row = $signed({1'b0, i_in.out_row});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: six products
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p[0] <= $signed(i_coefs[REG_X_COL]) * s_col;
            r_p[1] <= $signed(i_coefs[REG_X_ROW]) * s_row;
            r_p[2] <= $signed(i_coefs[REG_Y_COL]) * s_col;
            r_p[3] <= $signed(i_coefs[REG_Y_ROW]) * s_row;
            r_p[4] <= $signed(i_coefs[REG_W_COL]) * s_col;
            r_p[5] <= $signed(i_coefs[REG_W_ROW]) * s_row;
            r_offx <= $signed(i_coefs[REG_X_OFF]);
            r_offy <= $signed(i_coefs[REG_Y_OFF]);
            r_dr1  <= 9'(OUT_SIZE - 1 - int'(i_in.out_row));
            r_dc1  <= i_in.out_col;
        end
    end

    // stage 2: sums
    always_comb begin
        n_sx = SUM_W'(r_p[0]) + SUM_W'(r_p[1]) + SUM_W'(r_offx);
        n_sy = SUM_W'(r_p[2]) + SUM_W'(r_p[3]) + SUM_W'(r_offy);
        n_sw = SUM_W'(r_p[4]) + SUM_W'(r_p[5]) + Q_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sw  <= n_sw;
            r_dr2 <= r_dr1;
            r_dc2 <= r_dc1;
        end
    end

    // stage 3: magnitudes, signs, quotient overflow
    assign a_x  = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);
    assign a_y  = r_sy[SUM_W-1] ? SUM_W'(-r_sy) : SUM_W'(r_sy);
    assign a_w  = r_sw[SUM_W-1] ? SUM_W'(-r_sw) : SUM_W'(r_sw);
    assign w_sh = {a_w, {Q_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_mx            <= a_x;
            o_my            <= a_y;
            o_md            <= a_w;
            o_side.dest_row <= r_dr2;
            o_side.dest_col <= r_dc2;
            o_side.neg_x    <= r_sx[SUM_W-1] ^ r_sw[SUM_W-1];
            o_side.neg_y    <= r_sy[SUM_W-1] ^ r_sw[SUM_W-1];
            o_side.ov_x     <= {{Q_BITS{1'b0}}, a_x} >= w_sh;
            o_side.ov_y     <= {{Q_BITS{1'b0}}, a_y} >= w_sh;
            o_side.w_zero   <= (r_sw == '0);
        end
    end

    assign o_valid = r_v3;

endmodule

/* design/pwag_div.sv */
// Pipelined restoring divider, one quotient bit per stage for both axes.
module pwag_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_valid,
    input  pwag_pkg::t_side                 i_side,
    input  logic [pwag_pkg::SUM_W-1:0]      i_mx,
    input  logic [pwag_pkg::SUM_W-1:0]      i_my,
    input  logic [pwag_pkg::SUM_W-1:0]      i_md,
    output logic                            o_valid,
    output pwag_pkg::t_side                 o_side,
    output logic [pwag_pkg::Q_BITS-1:0]     o_qx,
    output logic [pwag_pkg::Q_BITS-1:0]     o_qy
);
    import pwag_pkg::*;

    logic [SUM_W-1:0]  r_rx [Q_BITS];
    logic [SUM_W-1:0]  r_ry [Q_BITS];
    logic [SUM_W-1:0]  r_d  [Q_BITS];
    logic [Q_BITS-1:0] r_qx [Q_BITS];
    logic [Q_BITS-1:0] r_qy [Q_BITS];
    t_side             r_sd [Q_BITS];
    logic [Q_BITS-1:0] r_v;

    for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
        localparam int K = Q_BITS - 1 - s;
        logic [SUM_W-1:0]  rx_in, ry_in, d_in;
        logic [Q_BITS-1:0] qx_in, qy_in;
        t_side             sd_in;
        logic              v_in;
        logic [CMP_W-1:0]  dsh;
        logic              gx, gy;

        if (s == 0) begin : g_first
            assign rx_in = i_mx;
            assign ry_in = i_my;
            assign d_in  = i_md;
            assign qx_in = '0;
            assign qy_in = '0;
            assign sd_in = i_side;
            assign v_in  = i_valid;
        end else begin : g_next
            assign rx_in = r_rx[s-1];
            assign ry_in = r_ry[s-1];
            assign d_in  = r_d[s-1];
            assign qx_in = r_qx[s-1];
            assign qy_in = r_qy[s-1];
            assign sd_in = r_sd[s-1];
            assign v_in  = r_v[s-1];
        end

        assign dsh = {{Q_BITS{1'b0}}, d_in} << K;
        assign gx  = {{Q_BITS{1'b0}}, rx_in} >= dsh;
        assign gy  = {{Q_BITS{1'b0}}, ry_in} >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_adv) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rx[s] <= gx ? SUM_W'(rx_in - dsh[SUM_W-1:0]) : rx_in;
                r_ry[s] <= gy ? SUM_W'(ry_in - dsh[SUM_W-1:0]) : ry_in;
                r_d[s]  <= d_in;
                r_qx[s] <= qx_in | (Q_BITS'(gx) << K);
                r_qy[s] <= qy_in | (Q_BITS'(gy) << K);
                r_sd[s] <= sd_in;
            end
        end
    end

    assign o_valid = r_v[Q_BITS-1];
    assign o_side  = r_sd[Q_BITS-1];
    assign o_qx    = r_qx[Q_BITS-1];
    assign o_qy    = r_qy[Q_BITS-1];

endmodule

/* design/perspective_warp_address_generator_top.sv */
// Top level of the perspective warp address generator: registers, pipeline, bounds check.
//
//   channel  | direction | handshake                    | payload
//   in       | input     | i_in_valid / o_in_ready      | i_in  (t_in)
//   out      | output    | o_out_valid / i_out_ready    | o_out (t_out)
//   cfg      | input     | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
// One request per cycle while the output is not stalled; the pipeline has three multiply/sum stages,
// one divider stage per quotient bit and one bounds-check output stage.
// Synchronous active-low reset clears all valid bits and loads the coefficient defaults.
// A stall on the output freezes the whole pipeline; o_in_ready drops only while the
// output register holds a request that is not taken.
module perspective_warp_address_generator_top #(
    parameter int OUT_SIZE   = 512,
    parameter int SRC_WIDTH  = 1024,
    parameter int SRC_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pwag_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pwag_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  logic [pwag_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [pwag_pkg::COEF_W-1:0]      i_cfg_data
);
    import pwag_pkg::*;

    localparam logic [Q_BITS-1:0] LIM_X = Q_BITS'(SRC_WIDTH);
    localparam logic [Q_BITS-1:0] LIM_Y = Q_BITS'(SRC_HEIGHT);

    t_coefs            r_coefs;
    logic              adv;
    logic              mac_valid, div_valid;
    t_side             mac_side, div_side;
    logic [SUM_W-1:0]  mx, my, md;
    logic [Q_BITS-1:0] qx, qy;
    logic              in_x, in_y, in_bounds;
    logic              r_out_valid;
    t_out              r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= COEF_RESET;
        end else if (i_cfg_we && (i_cfg_idx < IDX_W'(NUM_REGS))) begin
            r_coefs[i_cfg_idx[SEL_W-1:0]] <= i_cfg_data;
        end
    end

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    pwag_mac #(.OUT_SIZE(OUT_SIZE)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_in    (i_in),
        .i_coefs (r_coefs),
        .o_valid (mac_valid),
        .o_side  (mac_side),
        .o_mx    (mx),
        .o_my    (my),
        .o_md    (md)
    );

    pwag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (mac_valid),
        .i_side  (mac_side),
        .i_mx    (mx),
        .i_my    (my),
        .i_md    (md),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_qx    (qx),
        .o_qy    (qy)
    );

    // a negative quotient is inside only when it truncates to zero
    assign in_x      = !div_side.ov_x && (!div_side.neg_x || qx == '0) && (qx < LIM_X);
    assign in_y      = !div_side.ov_y && (!div_side.neg_y || qy == '0) && (qy < LIM_Y);
    assign in_bounds = !div_side.w_zero && in_x && in_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.src_x      <= in_bounds ? qx[9:0] : 10'd0;
            r_out.src_y      <= in_bounds ? qy[9:0] : 10'd0;
            r_out.inside_res <= in_bounds;
            r_out.dest_row   <= div_side.dest_row;
            r_out.dest_col   <= div_side.dest_col;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && div_valid && div_side.w_zero) |=> !o_out.inside_res)
        else $error("zero denominator reported inside");
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.inside_res) |-> (o_out.src_x == '0 && o_out.src_y == '0))
        else $error("outside pixel with nonzero source");
    a_ovf_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && div_valid && (div_side.ov_x || div_side.ov_y)) |=> !o_out.inside_res)
        else $error("overflowed quotient reported inside");
`endif

endmodule
